// ----- rtl/core/stsyn_pkg.sv -----
// Shared types, constants and tables for the sine tone synthesizer.
// Used by stsyn_mul, stsyn_div and sine_tone_synthesizer; depends on nothing.
package stsyn_pkg;

    // Phase counter and its modulus (one full sine period)
    localparam int unsigned PHASE_W = 16;
    localparam logic [PHASE_W-1:0] PHASE_MODULUS = 16'd44100;

    // Configuration register indexes and widths
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd1;
    localparam int unsigned STEP_W = 16;
    localparam int unsigned AMP_W  = 15;
    localparam logic [STEP_W-1:0] TONE_STEP_RESET = 16'd200;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RESET = 15'd0;

    // Sample format: Q1.15 sine times amplitude, shifted back by 15
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned Q_FRAC   = 15;
    localparam logic [SAMPLE_W-1:0] SINE_POS_MAX = 16'd32767;
    localparam logic [SAMPLE_W-1:0] SINE_NEG_MAX = 16'd32768;

    // Q2.62 datapath
    localparam int unsigned WORD_W = 64;
    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned Q62    = 62;
    localparam logic [WORD_W-1:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [WORD_W-1:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [WORD_W-1:0] ROUND_Q47   = 64'h0000_4000_0000_0000;
    localparam int unsigned SMAG_LSB = 47;

    // Divider operand width (covers the modulus and the series divisors)
    localparam int unsigned DEN_W = 16;

    // Taylor series length
    localparam int unsigned K_W = 4;
    localparam logic [K_W-1:0] TAYLOR_TERMS = 4'd12;

    // Request and response words for the shared multiplier
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] q62;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

    // Request and response words for the shared divider
    typedef struct packed {
        logic              start;
        logic [DEN_W-1:0]  rem;
        logic [WORD_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
        logic [DEN_W-1:0]  rem;
    } t_div_rsp;

    // Series divisor (2k)(2k+1) for term k
    function automatic logic [DEN_W-1:0] taylor_div(input logic [K_W-1:0] k);
        logic [DEN_W-1:0] d;
        case (k)
            4'd1:    d = 16'd6;
            4'd2:    d = 16'd20;
            4'd3:    d = 16'd42;
            4'd4:    d = 16'd72;
            4'd5:    d = 16'd110;
            4'd6:    d = 16'd156;
            4'd7:    d = 16'd210;
            4'd8:    d = 16'd272;
            4'd9:    d = 16'd342;
            4'd10:   d = 16'd420;
            4'd11:   d = 16'd506;
            4'd12:   d = 16'd600;
            default: d = 16'd1;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/stsyn_mul.sv -----
// Shared 64x64 multiplier built from one 32x32 multiplier and four partial products.
// Returns the full product and its Q2.62 slice; depends on stsyn_pkg.
module stsyn_mul
    import stsyn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int unsigned HALF_W = WORD_W / 2;
    localparam int unsigned CNT_W  = 3;
    localparam logic [CNT_W-1:0] LAST_CNT = 3'd4;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_pp;
    logic [1:0]        r_sel;
    logic [PROD_W-1:0] r_acc;

    logic [HALF_W-1:0] ma;
    logic [HALF_W-1:0] mb;
    logic [WORD_W-1:0] pp;
    logic [PROD_W-1:0] pp_sh;

    // Pick the halves for this partial product: ll, lh, hl, hh
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                ma = r_a[HALF_W-1:0];
                mb = r_b[HALF_W-1:0];
            end
            2'd1: begin
                ma = r_a[HALF_W-1:0];
                mb = r_b[WORD_W-1:HALF_W];
            end
            2'd2: begin
                ma = r_a[WORD_W-1:HALF_W];
                mb = r_b[HALF_W-1:0];
            end
            default: begin
                ma = r_a[WORD_W-1:HALF_W];
                mb = r_b[WORD_W-1:HALF_W];
            end
        endcase
    end

    assign pp = WORD_W'(ma) * WORD_W'(mb);

    // Align the registered partial product by its weight
    always_comb begin
        case (r_sel)
            2'd0:    pp_sh = {{WORD_W{1'b0}}, r_pp};
            2'd1:    pp_sh = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            2'd2:    pp_sh = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            default: pp_sh = {r_pp, {WORD_W{1'b0}}};
        endcase
    end

    // Sequence the four partial products and accumulate each in the cycle after it is formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp  <= pp;
            r_sel <= r_cnt[1:0];
            if (r_cnt != '0) begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
    assign o_rsp.q62  = r_acc[Q62+WORD_W-1:Q62];

endmodule

// ----- rtl/core/stsyn_div.sv -----
// Shared restoring divider, four quotient bits per cycle over a 64-bit word.
// Takes an initial remainder below the divisor; depends on stsyn_pkg.
module stsyn_div
    import stsyn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned STEPS    = 4;
    localparam int unsigned CYCLES   = WORD_W / STEPS;
    localparam int unsigned CNT_W    = $clog2(CYCLES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CYCLES - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W-1:0]  n_rem;
    logic [WORD_W-1:0] n_quo;
    logic [DEN_W-1:0]  rem_v;
    logic [WORD_W-1:0] quo_v;
    logic [DEN_W:0]    trial;

    // Shift in one dividend bit per step, subtract where it fits
    always_comb begin
        rem_v = r_rem;
        quo_v = r_quo;
        trial = '0;
        for (int i = 0; i < STEPS; i++) begin
            trial = {rem_v, quo_v[WORD_W-1]};
            quo_v = {quo_v[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                rem_v    = DEN_W'(trial - {1'b0, r_den});
                quo_v[0] = 1'b1;
            end else begin
                rem_v = trial[DEN_W-1:0];
            end
        end
        n_rem = rem_v;
        n_quo = quo_v;
    end

    // Count the passes over the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then advance remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- rtl/core/sine_tone_synthesizer.sv -----
// Sine tone synthesizer top level: sequencer, phase and config registers.
// Instantiates stsyn_mul and stsyn_div; depends on stsyn_pkg.
//
// Each accepted input word requests one audio sample. The block holds a phase
// counter modulo 44100 and returns amplitude * sin(2*pi*phase/44100), the sine
// rounded to Q1.15 (positive peak held at 32767) and the product shifted right
// by 15, then advances the phase by tone_step. The end-of-block flag of the
// request comes back with its sample. The sine is evaluated in Q2.62 fixed
// point by a quarter-wave reduction and a thirteen-term Taylor series. One item
// passes through the shared divider 15 times (14 when the phase sits on a
// quarter-wave peak), which yields four quotient bits a cycle over a 64-bit
// word, and through the shared four-partial-product multiplier 15 times; no new
// request is taken until the item is finished. A finished sample waits in the
// output register, and the next request is taken meanwhile.
// Write tone_step and amplitude only while no request is in flight.
module sine_tone_synthesizer
    import stsyn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_end_of_block,
    // sample channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SAMPLE_W-1:0]  o_sample,
    output logic                 o_last_of_block,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUAD,
        S_FRAC,
        S_XMUL,
        S_X2MUL,
        S_TMUL,
        S_TDIV,
        S_ROUND,
        S_AMUL,
        S_WRAP,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [STEP_W-1:0]   r_tone_step, n_tone_step;
    logic [AMP_W-1:0]    r_amplitude, n_amplitude;
    logic                r_eob, n_eob;
    logic [1:0]          r_quad, n_quad;
    logic [WORD_W-1:0]   r_term, n_term;
    logic [WORD_W-1:0]   r_sum, n_sum;
    logic [WORD_W-1:0]   r_x2, n_x2;
    logic [K_W-1:0]      r_k, n_k;
    logic [SAMPLE_W-1:0] r_result, n_result;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic                r_last, n_last;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [PHASE_W-1:0]     quarter_t;
    logic [WORD_W-1:0]      rounded;
    logic [SAMPLE_W:0]      smag_raw;
    logic [SAMPLE_W-1:0]    smag;
    logic [SAMPLE_W-1:0]    mag;
    logic [PHASE_W:0]       wrap_sum;

    stsyn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    stsyn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Fold the position within the quadrant onto the rising quarter wave
    assign quarter_t = div_rsp.quo[0] ? (PHASE_MODULUS - div_rsp.rem) : div_rsp.rem;

    // Round the Q2.62 sine to Q1.15 and hold it at the peak for its sign
    assign rounded  = r_sum + ROUND_Q47;
    assign smag_raw = rounded[SMAG_LSB+SAMPLE_W:SMAG_LSB];
    always_comb begin
        if (r_quad[1]) begin
            smag = (smag_raw > {1'b0, SINE_NEG_MAX}) ? SINE_NEG_MAX
                                                      : smag_raw[SAMPLE_W-1:0];
        end else begin
            smag = (smag_raw > {1'b0, SINE_POS_MAX}) ? SINE_POS_MAX
                                                      : smag_raw[SAMPLE_W-1:0];
        end
    end

    assign mag      = mul_rsp.prod[Q_FRAC+SAMPLE_W-1:Q_FRAC];
    assign wrap_sum = {1'b0, r_phase} + {1'b0, r_tone_step};

    // Sequencer: issue unit requests and collect their results
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_tone_step = r_tone_step;
        n_amplitude = r_amplitude;
        n_eob       = r_eob;
        n_quad      = r_quad;
        n_term      = r_term;
        n_sum       = r_sum;
        n_x2        = r_x2;
        n_k         = r_k;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_last      = r_last;
        mul_req     = '0;
        div_req     = '0;

        // Drop the output word once it is taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Register writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TONE_STEP: n_tone_step = i_cfg_data[STEP_W-1:0];
                CFG_AMPLITUDE: n_amplitude = i_cfg_data[AMP_W-1:0];
                default:       ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                // Split 4*phase into quadrant and remainder
                if (i_in_valid) begin
                    n_eob         = i_end_of_block;
                    div_req.start = 1'b1;
                    div_req.num   = WORD_W'({r_phase, 2'b00});
                    div_req.den   = DEN_W'(PHASE_MODULUS);
                    n_state       = S_QUAD;
                end
            end
            S_QUAD: begin
                if (div_rsp.done) begin
                    n_quad = div_rsp.quo[1:0];
                    if (quarter_t == PHASE_MODULUS) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = HALF_PI_Q62;
                        mul_req.b     = ONE_Q62;
                        n_state       = S_XMUL;
                    end else begin
                        // t/M as a 64-bit fraction, kept to 62 bits
                        div_req.start = 1'b1;
                        div_req.rem   = DEN_W'(quarter_t);
                        div_req.den   = DEN_W'(PHASE_MODULUS);
                        n_state       = S_FRAC;
                    end
                end
            end
            S_FRAC: begin
                if (div_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = HALF_PI_Q62;
                    mul_req.b     = {2'b00, div_rsp.quo[WORD_W-1:2]};
                    n_state       = S_XMUL;
                end
            end
            S_XMUL: begin
                // Angle x is the first term and the first partial sum
                if (mul_rsp.done) begin
                    n_term        = mul_rsp.q62;
                    n_sum         = mul_rsp.q62;
                    n_k           = K_W'(1);
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.q62;
                    mul_req.b     = mul_rsp.q62;
                    n_state       = S_X2MUL;
                end
            end
            S_X2MUL: begin
                if (mul_rsp.done) begin
                    n_x2          = mul_rsp.q62;
                    mul_req.start = 1'b1;
                    mul_req.a     = r_term;
                    mul_req.b     = mul_rsp.q62;
                    n_state       = S_TMUL;
                end
            end
            S_TMUL: begin
                if (mul_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_rsp.q62;
                    div_req.den   = taylor_div(r_k);
                    n_state       = S_TDIV;
                end
            end
            S_TDIV: begin
                // Alternate the sign of the terms, then go on or finish
                if (div_rsp.done) begin
                    n_term = div_rsp.quo;
                    n_sum  = r_k[0] ? (r_sum - div_rsp.quo) : (r_sum + div_rsp.quo);
                    if (r_k == TAYLOR_TERMS) begin
                        n_state = S_ROUND;
                    end else begin
                        n_k           = r_k + 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = div_rsp.quo;
                        mul_req.b     = r_x2;
                        n_state       = S_TMUL;
                    end
                end
            end
            S_ROUND: begin
                mul_req.start = 1'b1;
                mul_req.a     = WORD_W'(r_amplitude);
                mul_req.b     = WORD_W'(smag);
                n_state       = S_AMUL;
            end
            S_AMUL: begin
                // Apply the sign, then reduce the advanced phase
                if (mul_rsp.done) begin
                    n_result      = r_quad[1] ? (SAMPLE_W'(0) - mag) : mag;
                    div_req.start = 1'b1;
                    div_req.num   = WORD_W'(wrap_sum);
                    div_req.den   = DEN_W'(PHASE_MODULUS);
                    n_state       = S_WRAP;
                end
            end
            S_WRAP: begin
                if (div_rsp.done) begin
                    n_phase = div_rsp.rem[PHASE_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_sample    = r_result;
                    n_last      = r_eob;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_tone_step <= TONE_STEP_RESET;
            r_amplitude <= AMPLITUDE_RESET;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_tone_step <= n_tone_step;
            r_amplitude <= n_amplitude;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
        end
        r_eob    <= n_eob;
        r_quad   <= n_quad;
        r_term   <= n_term;
        r_sum    <= n_sum;
        r_x2     <= n_x2;
        r_result <= n_result;
        r_sample <= n_sample;
        r_last   <= n_last;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_sample;
    assign o_last_of_block = r_last;

endmodule
